/* hdl/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and the byte encoder of the utf-16 to utf-8 block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

   localparam logic [15:0] SURR_MASK       = 16'hFC00;
   localparam logic [15:0] SURR_RANGE_MASK = 16'hF800;
   localparam logic [15:0] HIGH_SURR       = 16'hD800;
   localparam logic [15:0] LOW_SURR        = 16'hDC00;
   localparam logic [20:0] SUPP_BASE       = 21'h010000;
   localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
   localparam logic [7:0]  TERM_BYTE       = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one queued word: code point, number of utf-8 bytes, terminator flag
   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        term;
   } desc_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QUEUE_CW-1:0] level;
   } queue_status_type;

   function automatic logic [7:0] utf8_byte(desc_type d, logic [2:0] idx);
      logic [7:0] b;
      b = TERM_BYTE;
      unique case (d.byte_count)
         3'd1: begin
            if (idx == 3'd0) b = {1'b0, d.code_point[6:0]};
         end
         3'd2: begin
            if (idx == 3'd0) b = {3'b110, d.code_point[10:6]};
            else if (idx == 3'd1) b = {2'b10, d.code_point[5:0]};
         end
         3'd3: begin
            if (idx == 3'd0) b = {4'b1110, d.code_point[15:12]};
            else if (idx == 3'd1) b = {2'b10, d.code_point[11:6]};
            else if (idx == 3'd2) b = {2'b10, d.code_point[5:0]};
         end
         3'd4: begin
            if (idx == 3'd0) b = {5'b11110, d.code_point[20:18]};
            else if (idx == 3'd1) b = {2'b10, d.code_point[17:12]};
            else if (idx == 3'd2) b = {2'b10, d.code_point[11:6]};
            else if (idx == 3'd3) b = {2'b10, d.code_point[5:0]};
         end
         default: b = TERM_BYTE;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

/* hdl/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// classifies code units, pairs surrogates and builds queue words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [15:0]          code_unit,
   input  wire logic                 last_unit,
   output logic                      push,
   output u16u8_pkg::desc_type       desc
);
   import u16u8_pkg::*;

   logic       high_pending_ff, high_pending_in;
   logic [9:0] held_high_ff, held_high_in;
   logic       is_high, is_low, is_surr;

   assign is_high = (code_unit & SURR_MASK) == HIGH_SURR;
   assign is_low  = (code_unit & SURR_MASK) == LOW_SURR;
   assign is_surr = (code_unit & SURR_RANGE_MASK) == HIGH_SURR;

   always_comb begin
      high_pending_in = high_pending_ff;
      held_high_in    = held_high_ff;
      desc.code_point = {5'd0, code_unit};
      desc.byte_count = 3'd0;
      desc.term       = last_unit;
      priority if (high_pending_ff) begin
         if (is_low) begin
            desc.code_point = SUPP_BASE + {1'b0, held_high_ff, code_unit[9:0]};
            desc.byte_count = 3'd4;
         end
         high_pending_in = 1'b0;
         held_high_in    = 10'd0;
      end else if (is_high) begin
         high_pending_in = 1'b1;
         held_high_in    = code_unit[9:0];
      end else if (is_surr) begin
         desc.byte_count = 3'd0;
      end else if (code_unit < ONE_BYTE_LIMIT) begin
         desc.byte_count = 3'd1;
      end else if (code_unit < TWO_BYTE_LIMIT) begin
         desc.byte_count = 3'd2;
      end else begin
         desc.byte_count = 3'd3;
      end
      if (last_unit) begin
         high_pending_in = 1'b0;
         held_high_in    = 10'd0;
      end
   end

   assign push = accept && ((desc.byte_count != 3'd0) || desc.term);

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         held_high_ff    <= 10'd0;
      end else if (accept) begin
         high_pending_ff <= high_pending_in;
         held_high_ff    <= held_high_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// short fifo of words between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire u16u8_pkg::desc_type    push_desc,
   input  wire logic                   pop,
   output u16u8_pkg::desc_type         head_desc,
   output u16u8_pkg::queue_status_type status
);
   import u16u8_pkg::*;

   desc_type            mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0] level_ff, level_in;
   logic                do_push, do_pop;

   assign status.level = level_ff;
   assign status.full  = level_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign status.empty = level_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_desc    = mem[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (do_push && !do_pop) level_in = level_ff + QUEUE_CW'(1);
      else if (do_pop && !do_push) level_in = level_ff - QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// serialises queued words into utf-8 bytes on a registered output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire u16u8_pkg::desc_type head_desc,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_end_of_string
);
   import u16u8_pkg::*;

   desc_type   cur_ff;
   logic       busy_ff;
   logic [2:0] idx_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_eos_ff;
   logic [2:0] total;
   logic       out_free, emit, done;

   assign total    = cur_ff.byte_count + {2'b00, cur_ff.term};
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign done     = emit && (idx_ff == total - 3'd1);
   assign pop      = head_valid && (!busy_ff || done);

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head_desc;
      if (emit) begin
         out_byte_ff <= utf8_byte(cur_ff, idx_ff);
         out_eos_ff  <= cur_ff.term && (idx_ff == cur_ff.byte_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= 3'd0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_of_string = out_eos_ff;

endmodule

`default_nettype wire

/* hdl/utf16_to_utf8_converter_top.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter_top
// utf-16 code units in, utf-8 bytes out, zero terminator after the last unit
// ----------------------------------------------------------------------------
// One 16-bit code unit is taken per cycle while the four-word queue between
// the classifier and the byte serialiser has room. Units that produce no byte
// (a held high surrogate, a dropped or lone surrogate not marked last) never
// enter the queue. Every other unit becomes one queue word, which the
// byte-wide serialiser sends out one byte at a time: one byte for ascii, up
// to three for other basic-plane units, four for a surrogate pair and one
// more zero byte for the terminator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_converter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_string
);
   import u16u8_pkg::*;

   logic             accept, push, pop;
   desc_type         push_desc, head_desc;
   queue_status_type q_status;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_unit (req_code_unit),
      .last_unit (req_last_unit),
      .push      (push),
      .desc      (push_desc)
   );

   u16u8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   u16u8_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (!q_status.empty),
      .head_desc         (head_desc),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string)
   );

   // queue never overfills
   a_level: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue level above depth");

   // terminator word is always zero
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_out_byte == TERM_BYTE)
      else $error("terminator word not zero");

   // full queue with no pop stays full and blocks input
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      q_status.full && !pop |=> !req_ready)
      else $error("full queue released without a pop");

   // nothing shown on the output right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

endmodule

`default_nettype wire
